### design/spq_pkg.sv
// shared types and constants for the stable priority queue
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int TAG_BITS_DEF      = 16;

  // widths of the transaction fields at the ports
  localparam int FIELD_PRIO_W = 16;
  localparam int FIELD_TAG_W  = 16;
  localparam int FIELD_OCC_W  = 5;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/spq_cell.sv
// one slot of the sorted chain: holds an entry, shifts right on insert, left on removal
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic [PRIORITY_BITS-1:0] new_prio,
  input  wire logic [TAG_BITS-1:0]      new_tag,
  input  wire logic                     left_valid,
  input  wire logic                     left_gt,
  input  wire logic [PRIORITY_BITS-1:0] left_prio,
  input  wire logic [TAG_BITS-1:0]      left_tag,
  input  wire logic                     right_valid,
  input  wire logic [PRIORITY_BITS-1:0] right_prio,
  input  wire logic [TAG_BITS-1:0]      right_tag,
  output logic                          valid,
  output logic                          gt,
  output logic [PRIORITY_BITS-1:0]      prio,
  output logic [TAG_BITS-1:0]           tag
);

  logic                     valid_r, valid_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]      tag_r, tag_nxt;

  // empty slot or strictly larger priority: new entry goes at or before here
  assign gt = !valid_r || (prio_r > new_prio);

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    tag_nxt   = tag_r;
    if (ctrl.enq) begin
      valid_nxt = valid_r | left_valid;
      if (gt) begin
        if (left_gt) begin
          prio_nxt = left_prio;
          tag_nxt  = left_tag;
        end else begin
          prio_nxt = new_prio;
          tag_nxt  = new_tag;
        end
      end
    end else if (ctrl.deq) begin
      valid_nxt = right_valid;
      prio_nxt  = right_prio;
      tag_nxt   = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign valid = valid_r;
  assign prio  = prio_r;
  assign tag   = tag_r;

endmodule

`default_nettype wire

### design/stable_priority_queue_unit.sv
// top level of the stable priority queue: chain of sorted cells plus result register
// the result of a transaction is presented in the cycle after it is accepted
// one enqueue or dequeue per cycle if not stalled; all cells compare and shift in parallel
// input is taken whenever the result register is empty or being drained in the same cycle
// reset (rst_n low, synchronous) empties the queue and the result register
// slot contents carry no reset; only occupied slots are ever presented
`default_nettype none

module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // entry_priority[15:0], entry_tag[31:16]
  input  wire logic        in_tuser,   // mode
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // head_priority[15:0], head_tag[31:16],
                                       // occupancy[36:32], zero fill[39:37]
  output logic [2:0]       out_tuser   // head_valid[0], status[2:1]
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // transaction decode
  logic                     in_accept;
  mode_t                    in_mode;
  logic [31:0]              prio_ext;
  logic [31:0]              tag_ext;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [TAG_BITS-1:0]      new_tag;

  assign in_accept = in_tvalid && in_tready;
  assign in_mode   = mode_t'(in_tuser);
  assign prio_ext  = 32'(in_tdata[15:0]);
  assign tag_ext   = 32'(in_tdata[31:16]);
  assign new_prio  = prio_ext[PRIORITY_BITS-1:0];
  assign new_tag   = tag_ext[TAG_BITS-1:0];

  // cell chain outputs
  logic                     cell_valid [DEPTH];
  logic                     cell_gt    [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio  [DEPTH];
  logic [TAG_BITS-1:0]      cell_tag   [DEPTH];

  logic       q_full, q_empty;
  cell_ctrl_t ctrl;

  // queue is sorted and packed toward the head, so the end cells tell full/empty
  assign q_full  = cell_valid[DEPTH-1];
  assign q_empty = !cell_valid[0];

  assign ctrl.enq = in_accept && (in_mode == MODE_ENQ) && !q_full;
  assign ctrl.deq = in_accept && (in_mode == MODE_DEQ) && !q_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_valid, l_gt, r_valid;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;
    logic [TAG_BITS-1:0]      l_tag, r_tag;

    if (i == 0) begin : g_head
      // head has an implicit occupied, non-greater neighbor on its left
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
      assign l_prio  = '0;
      assign l_tag   = '0;
    end else begin : g_mid_l
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
      assign l_prio  = cell_prio[i-1];
      assign l_tag   = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // tail shifts in an empty slot on removal
      assign r_valid = 1'b0;
      assign r_prio  = '0;
      assign r_tag   = '0;
    end else begin : g_mid_r
      assign r_valid = cell_valid[i+1];
      assign r_prio  = cell_prio[i+1];
      assign r_tag   = cell_tag[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .TAG_BITS     (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_prio   (new_prio),
      .new_tag    (new_tag),
      .left_valid (l_valid),
      .left_gt    (l_gt),
      .left_prio  (l_prio),
      .left_tag   (l_tag),
      .right_valid(r_valid),
      .right_prio (r_prio),
      .right_tag  (r_tag),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i]),
      .prio       (cell_prio[i]),
      .tag        (cell_tag[i])
    );
  end

  // occupancy counter and result register
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = status_r;
    if (in_accept) begin
      if (in_mode == MODE_ENQ) begin
        status_nxt = q_full ? ST_FULL : ST_DONE;
      end else begin
        status_nxt = q_empty ? ST_EMPTY : ST_DONE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a new transaction only enters when the pending result leaves, so the head cell
  // holds still while a result waits and can be presented directly
  assign in_tready = !out_valid_r || out_tready;

  logic [31:0] head_prio_ext, head_tag_ext, count_ext;
  logic        head_valid;

  assign head_valid    = cell_valid[0];
  assign head_prio_ext = head_valid ? 32'(cell_prio[0]) : 32'd0;
  assign head_tag_ext  = head_valid ? 32'(cell_tag[0]) : 32'd0;
  assign count_ext     = 32'(count_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, count_ext[FIELD_OCC_W-1:0],
                       head_tag_ext[FIELD_TAG_W-1:0], head_prio_ext[FIELD_PRIO_W-1:0]};
  assign out_tuser  = {status_r, head_valid};

endmodule

`default_nettype wire

### test/spq_checker.sv
// checker for the stable priority queue: predicts each result and compares it
`timescale 1ns / 100ps

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  output int               fail_count,
  output int               pending_results
);

  typedef struct packed {
    logic                    head_valid;
    logic [FIELD_PRIO_W-1:0] head_prio;
    logic [FIELD_TAG_W-1:0]  head_tag;
    logic [FIELD_OCC_W-1:0]  occ;
    status_t                 status;
  } head_report_t;

  // own copy of the sorted queue
  logic [FIELD_PRIO_W-1:0] slot_prio [DEPTH];
  logic [FIELD_TAG_W-1:0]  slot_tag  [DEPTH];
  int unsigned             held;

  head_report_t head_reports_due [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    held            = 0;
  end

  task automatic apply_command(input mode_t cmd, input logic [FIELD_PRIO_W-1:0] prio,
                               input logic [FIELD_TAG_W-1:0] tag,
                               output head_report_t rpt);
    int unsigned pos;
    int unsigned k;
    rpt = '0;
    rpt.status = ST_DONE;
    if (cmd == MODE_ENQ) begin
      if (held >= DEPTH) begin
        rpt.status = ST_FULL;
      end else begin
        // behind every entry of equal priority
        pos = 0;
        while (pos < held && slot_prio[pos] <= prio) pos++;
        for (k = held; k > pos; k--) begin
          slot_prio[k] = slot_prio[k-1];
          slot_tag[k]  = slot_tag[k-1];
        end
        slot_prio[pos] = prio;
        slot_tag[pos]  = tag;
        held++;
      end
    end else begin
      if (held == 0) begin
        rpt.status = ST_EMPTY;
      end else begin
        for (k = 1; k < held; k++) begin
          slot_prio[k-1] = slot_prio[k];
          slot_tag[k-1]  = slot_tag[k];
        end
        held--;
      end
    end
    if (held > 0) begin
      rpt.head_valid = 1'b1;
      rpt.head_prio  = slot_prio[0];
      rpt.head_tag   = slot_tag[0];
    end
    rpt.occ = held[FIELD_OCC_W-1:0];
  endtask

  always @(posedge clk) begin
    head_report_t due;
    head_report_t seen;
    head_report_t fresh;
    if (!rst_n) begin
      held = 0;
      head_reports_due.delete();
    end else begin
      // results first: a result accepted now belongs to an earlier transaction
      if (out_tvalid && out_tready) begin
        seen.head_valid = out_tuser[0];
        seen.status     = status_t'(out_tuser[2:1]);
        seen.head_prio  = out_tdata[15:0];
        seen.head_tag   = out_tdata[31:16];
        seen.occ        = out_tdata[36:32];
        if (head_reports_due.size() == 0) begin
          $error("unexpected result: tdata %h tuser %h", out_tdata, out_tuser);
          fail_count++;
        end else begin
          due = head_reports_due.pop_front();
          if (seen.head_valid !== due.head_valid) begin
            $error("head_valid: expected %0d, got %0d", due.head_valid, seen.head_valid);
            fail_count++;
          end
          if (seen.head_prio !== due.head_prio) begin
            $error("head_priority: expected %h, got %h", due.head_prio, seen.head_prio);
            fail_count++;
          end
          if (seen.head_tag !== due.head_tag) begin
            $error("head_tag: expected %h, got %h", due.head_tag, seen.head_tag);
            fail_count++;
          end
          if (seen.occ !== due.occ) begin
            $error("occupancy: expected %0d, got %0d", due.occ, seen.occ);
            fail_count++;
          end
          if (out_tuser[2:1] !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_tuser[2:1]);
            fail_count++;
          end
          if (out_tdata[39:37] !== 3'b000) begin
            $error("zero fill: expected 0, got %0d", out_tdata[39:37]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_command(mode_t'(in_tuser), in_tdata[15:0], in_tdata[31:16], fresh);
        head_reports_due.push_back(fresh);
      end
    end
    pending_results = head_reports_due.size();
  end

endmodule

### test/tb_top.sv
// top of the stable priority queue testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top
  import spq_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 530;
  localparam int HOLD_CYCLES  = 80;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // entry_priority[15:0], entry_tag[31:16]
  logic        in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // head_priority[15:0], head_tag[31:16], occupancy[36:32]
  logic [2:0]  out_tuser;  // head_valid[0], status[2:1]

  int fail_count;
  int pending_results;
  int cycle_count;

  // burst bookkeeping for the sender
  int burst_left;
  // set by the stimulus, taken up by the receiver to start a long hold-off
  bit hold_start;

  stable_priority_queue_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  spq_checker u_queue_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: a long hold-off on request, otherwise one of four stall patterns, drawn anew at random
  initial begin
    int hold_left;
    int pattern;
    int pattern_left;
    int phase;
    hold_left    = 0;
    pattern      = 0;
    pattern_left = 0;
    phase        = 0;
    out_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (pattern_left == 0) begin
        pattern      = $urandom_range(0, 3);
        pattern_left = $urandom_range(40, 160);
      end
      pattern_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_start) begin
        // block fills its result register and then back-pressures the sender
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        case (pattern)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  // offer one transaction, opening a random gap when the current burst runs out;
  // called at a rising edge and returns at the edge where the transaction is taken
  task automatic send_item(input mode_t cmd, input logic [15:0] prio,
                           input logic [15:0] tag);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(0, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {tag, prio};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int enq_percent;
    int prio_style;
    int seg_left;
    logic [15:0] prio;
    mode_t cmd;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_ENQ;
    hold_start = 1'b0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dequeue on an empty queue, with every ignored field bit set
    send_item(MODE_DEQ, 16'hFFFF, 16'hFFFF);
    // priority extremes; the lowest value must take the head
    send_item(MODE_ENQ, 16'hFFFF, 16'hFFFF);
    send_item(MODE_ENQ, 16'h0000, 16'h0000);
    // three equal priorities must leave in arrival order
    send_item(MODE_ENQ, 16'h8000, 16'h00A1);
    send_item(MODE_ENQ, 16'h8000, 16'h00A2);
    send_item(MODE_ENQ, 16'h8000, 16'h00A3);
    // fill up, ties with the lowest and highest values among them
    for (int i = 0; i < 11; i++) begin
      send_item(MODE_ENQ, (i % 3 == 0) ? 16'h0000 : (i % 3 == 1) ? 16'hFFFF : 16'h8000,
                16'(16'h0100 + i));
    end
    // enqueue into a full queue is dropped
    send_item(MODE_ENQ, 16'h0000, 16'h5A5A);
    send_item(MODE_DEQ, 16'h1234, 16'h5678);
    send_item(MODE_DEQ, 16'h0000, 16'h0000);

    // random: segments that lean toward filling or draining or stay balanced, so the queue
    // swings between full and empty, with a mix of priority spreads
    seg_left = 0;
    enq_percent = 50;
    prio_style  = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(15, 60);
        case ($urandom_range(0, 2))
          0:       enq_percent = 85;
          1:       enq_percent = 50;
          default: enq_percent = 15;
        endcase
        prio_style = $urandom_range(0, 2);
      end
      seg_left--;
      if (n == 150 || n == 400) hold_start = 1'b1;
      case (prio_style)
        0:       prio = 16'($urandom_range(0, 3));
        1:       prio = 16'($urandom_range(0, 65535));
        default: begin
          case ($urandom_range(0, 3))
            0:       prio = 16'h0000;
            1:       prio = 16'h0001;
            2:       prio = 16'hFFFE;
            default: prio = 16'hFFFF;
          endcase
        end
      endcase
      cmd = ($urandom_range(0, 99) < enq_percent) ? MODE_ENQ : MODE_DEQ;
      send_item(cmd, prio, 16'($urandom_range(0, 65535)));
    end
    in_tvalid <= 1'b0;

    // one more edge so the checker has logged the last transaction
    @(posedge clk);
    // drain; the watchdog covers a result that never comes
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_unit.sv
test/spq_checker.sv
test/tb_top.sv
